### rtl/sector_fixup_word_stream_defines.svh
// assertion macros shared by the sector fixup rtl
`ifndef SECTOR_FIXUP_WORD_STREAM_DEFINES_SVH
`define SECTOR_FIXUP_WORD_STREAM_DEFINES_SVH

// clocked check, masked while reset is high
`define SFX_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// clocked check that also holds across reset
`define SFX_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### rtl/sfx_pkg.sv
// ----------------------------------------------------------------------------
// sfx_pkg
// shared constants and types of the sector fixup word stream
// ----------------------------------------------------------------------------
`default_nettype none

package sfx_pkg;

   localparam int MAX_SECTORS  = 8;
   localparam int SECTOR_BYTES = 512;   // must give a power-of-two word count
   localparam int SLOT_COUNT   = MAX_SECTORS + 1;
   localparam int SECTOR_WORDS = SECTOR_BYTES / 2;

   localparam int WORD_W    = 16;
   localparam int OFFS_W    = 12;
   localparam int CNT_W     = 16;
   localparam int POS_W     = 11;
   localparam int SLOT_W    = $clog2(SLOT_COUNT);
   localparam int SEC_SHIFT = $clog2(SECTOR_WORDS);
   localparam int SEC_W     = POS_W - SEC_SHIFT;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic     wr_en;
      slot_type wr_addr;
      word_type wr_data;
      logic     rd_en;
      slot_type rd_addr;
   } ram_req_type;

   typedef struct packed {
      word_type word_out;
      logic     last_out;
      logic     replaced;
   } rsp_word_type;

endpackage

`default_nettype wire

### rtl/sfx_if.sv
// ----------------------------------------------------------------------------
// sfx_if
// valid/ready channels for record words in and fixed-up words out
// ----------------------------------------------------------------------------
`default_nettype none

interface sfx_req_if import sfx_pkg::*; ();
   logic              valid;
   logic              ready;
   word_type          data_word;
   logic              first_word;
   logic              tail_word;
   logic [OFFS_W-1:0] array_offset;
   logic [CNT_W-1:0]  array_entries;

   modport source (output valid, data_word, first_word, tail_word, array_offset,
                   array_entries, input ready);
   modport sink (input valid, data_word, first_word, tail_word, array_offset,
                 array_entries, output ready);
endinterface

interface sfx_rsp_if import sfx_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type word_out;
   logic     last_out;
   logic     replaced;

   modport source (output valid, word_out, last_out, replaced, input ready);
   modport sink (input valid, word_out, last_out, replaced, output ready);
endinterface

`default_nettype wire

### rtl/sector_fixup_word_stream.sv
// ----------------------------------------------------------------------------
// sector_fixup_word_stream
// update sequence array fixup on a stream of 16-bit record words
// ----------------------------------------------------------------------------
// Takes one record word per cycle and returns one word per cycle, as long as
// rsp does not stall. A word is registered in the stage that waits on the
// registered read of the saved-value RAM issued at each sector-end word and
// then sits in a two-entry output buffer, from which rsp takes it. Array
// entries are captured into that RAM as they stream past and the signature
// is also kept in a register. The output buffer lets req keep flowing while
// rsp stalls; req only stops once the buffer is full, rsp is not ready and
// the stage holds a word. No clearing pass is needed after reset: capture
// flags live in flip-flops and are cleared on each first word.
`default_nettype none

module sector_fixup_word_stream
   import sfx_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   sfx_req_if.sink   req_chan,
   sfx_rsp_if.source rsp_chan
);

`include "sector_fixup_word_stream_defines.svh"

   // record state
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [OFFS_W-1:0]     offs_ff, offs_in;
   logic [CNT_W-1:0]      ents_ff, ents_in;
   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   word_type              sig_ff, sig_in;

   // second stage
   logic     s2_valid_ff, s2_valid_in;
   word_type s2_word_ff;
   logic     s2_last_ff, s2_swap_ff, s2_fwd_ff;

   logic                  accept, buf_ready, s2_move;
   logic                  enabled, in_array, capture, sec_end, sec_ok, swap, fwd;
   logic [POS_W-1:0]      start, k;
   logic [SEC_W-1:0]      sec;
   slot_type              cap_slot, rd_slot;
   logic [SLOT_COUNT-1:0] valid_cur;
   ram_req_type           ram_req;
   word_type              rd_data;
   rsp_word_type          res;

   assign s2_move        = s2_valid_ff && buf_ready;
   assign req_chan.ready = !s2_valid_ff || buf_ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      pos_in    = req_chan.first_word ? '0 : pos_ff;
      offs_in   = req_chan.first_word ? req_chan.array_offset : offs_ff;
      ents_in   = req_chan.first_word ? req_chan.array_entries : ents_ff;
      valid_cur = req_chan.first_word ? '0 : valid_ff;

      enabled  = (offs_in != '0) && (ents_in >= CNT_W'(2));
      start    = offs_in[OFFS_W-1:1];
      in_array = pos_in >= start;
      k        = pos_in - start;
      capture  = enabled && in_array && (CNT_W'(k) < ents_in) &&
                 (k < POS_W'(SLOT_COUNT));
      cap_slot = k[SLOT_W-1:0];

      sec_end = &pos_in[SEC_SHIFT-1:0];
      sec     = pos_in[POS_W-1:SEC_SHIFT];
      rd_slot = SLOT_W'(sec) + SLOT_W'(1);
      sec_ok  = (CNT_W'(sec) < (ents_in - CNT_W'(1))) && (32'(sec) < MAX_SECTORS);

      // the word itself may be captured before the sector-end check
      valid_in = valid_cur | (capture ? (SLOT_COUNT'(1) << cap_slot) : '0);
      sig_in   = (capture && (cap_slot == '0)) ? req_chan.data_word : sig_ff;
      swap     = enabled && sec_end && sec_ok && valid_in[0] && valid_in[rd_slot] &&
                 (req_chan.data_word == sig_in);
      fwd      = capture && (cap_slot == rd_slot);

      ram_req.wr_en   = accept && capture;
      ram_req.wr_addr = cap_slot;
      ram_req.wr_data = req_chan.data_word;
      ram_req.rd_en   = accept && sec_end;
      ram_req.rd_addr = rd_slot;

      s2_valid_in = accept ? 1'b1 : (s2_move ? 1'b0 : s2_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         offs_ff     <= '0;
         ents_ff     <= '0;
         valid_ff    <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         if (accept) begin
            pos_ff   <= pos_in + POS_W'(1);
            offs_ff  <= offs_in;
            ents_ff  <= ents_in;
            valid_ff <= valid_in;
         end
      end
      if (accept) begin
         sig_ff     <= sig_in;
         s2_word_ff <= req_chan.data_word;
         s2_last_ff <= req_chan.tail_word;
         s2_swap_ff <= swap;
         s2_fwd_ff  <= fwd;
      end
   end

   sfx_save_ram u_save_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   always_comb begin
      res.word_out = s2_swap_ff ? (s2_fwd_ff ? s2_word_ff : rd_data) : s2_word_ff;
      res.last_out = s2_last_ff;
      res.replaced = s2_swap_ff;
   end

   sfx_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s2_valid_ff),
      .push_ready (buf_ready),
      .push_word  (res),
      .rsp_chan   (rsp_chan)
   );

   `SFX_ASSERT(a_rd_hold, (s2_valid_ff && s2_swap_ff && !s2_fwd_ff && !s2_move) |=> $stable(rd_data),
               "saved word changed under a stalled word")
   `SFX_ASSERT_ALWAYS(a_reset_empty, reset |=> !s2_valid_ff,
                      "pipe not empty after reset")
   `SFX_ASSERT(a_first_clear, (accept && req_chan.first_word) |=> ($countones(valid_ff) <= 1),
               "capture flags not cleared at record start")

endmodule

`default_nettype wire

### rtl/sfx_save_ram.sv
// ----------------------------------------------------------------------------
// sfx_save_ram
// update sequence array store: one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sfx_save_ram
   import sfx_pkg::*;
(
   input  wire         clock,
   input  ram_req_type ram_req,
   output word_type    rd_data
);

   word_type mem [SLOT_COUNT];
   word_type rd_data_ff;

   // read-first: a same-cycle write is forwarded by the caller
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/sfx_out_buf.sv
// ----------------------------------------------------------------------------
// sfx_out_buf
// two-entry output buffer so the pipe keeps taking words while rsp stalls, until it is full
// ----------------------------------------------------------------------------
`default_nettype none

module sfx_out_buf
   import sfx_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          push_valid,
   output logic         push_ready,
   input  rsp_word_type push_word,
   sfx_rsp_if.source    rsp_chan
);

`include "sector_fixup_word_stream_defines.svh"

   logic [1:0]   cnt_ff, cnt_in;
   rsp_word_type ent0_ff, ent0_in;
   rsp_word_type ent1_ff, ent1_in;
   logic         pop, push;

   assign pop        = (cnt_ff != 2'd0) && rsp_chan.ready;
   assign push_ready = (cnt_ff != 2'd2) || rsp_chan.ready;
   assign push       = push_valid && push_ready;

   always_comb begin
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
      ent0_in = ent0_ff;
      ent1_in = ent1_ff;
      if (pop) begin
         ent0_in = (cnt_ff == 2'd2) ? ent1_ff : push_word;
      end else if (cnt_ff == 2'd0) begin
         ent0_in = push_word;
      end
      if (push && (((cnt_ff == 2'd1) && !pop) || ((cnt_ff == 2'd2) && pop))) begin
         ent1_in = push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      ent0_ff <= ent0_in;
      ent1_ff <= ent1_in;
   end

   assign rsp_chan.valid    = cnt_ff != 2'd0;
   assign rsp_chan.word_out = ent0_ff.word_out;
   assign rsp_chan.last_out = ent0_ff.last_out;
   assign rsp_chan.replaced = ent0_ff.replaced;

   `SFX_ASSERT(a_cnt_range, cnt_ff != 2'd3, "output buffer count out of range")
   `SFX_ASSERT(a_cnt_grow, (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1),
               "output buffer lost a pushed word")

endmodule

`default_nettype wire
